@@ src/mis_pkg.sv @@
// Shared vertex mark codes and field widths for the maximal independent set solver.
package mis_pkg;
	localparam int MARK_BITS = 2;
	localparam logic [MARK_BITS-1:0] MARK_OUT  = 2'd0;
	localparam logic [MARK_BITS-1:0] MARK_IN   = 2'd1;
	localparam logic [MARK_BITS-1:0] MARK_OPEN = 2'd2;

	localparam int SLOT_BITS   = 14;
	localparam int NBR_BITS    = 10;
	localparam int VCOUNT_BITS = 11;
	localparam int INDEX_BITS  = 13;
	localparam int REQ_KEY_BITS = 32;
	localparam int ROUNDS_BITS = 7;

	localparam logic REG_VERTEX_COUNT    = 1'b0;
	localparam logic REG_ADJACENCY_COUNT = 1'b1;

	localparam logic [1:0] OP_LOAD_VERTEX = 2'd0;
	localparam logic [1:0] OP_LOAD_SLOT   = 2'd1;
	localparam logic [1:0] OP_SOLVE       = 2'd2;
	localparam logic [1:0] OP_READ        = 2'd3;

	localparam logic KIND_SOLVE = 1'b0;
	localparam logic KIND_READ  = 1'b1;
endpackage

@@ src/mis_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module mis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/maximal_independent_set_csr.sv @@
// Top level of the maximal independent set solver over a compressed adjacency graph.
// Usage: requests enter on start with operation and its fields, taken when busy is low.
// Loads of a vertex (first slot, candidate, key) or a neighbor slot are written at the
// accepting edge and give no result. A read request answers with kind = 1 and in_set,
// marked by a one-cycle done strobe: done is high in the cycle right after the accepting
// edge for an index beyond the vertex range, and in the cycle after that otherwise. A solve
// request runs Luby rounds and answers with kind = 0, rounds_used and failed. A solve first
// sets each vertex mark (open for a candidate, out otherwise), then per round copies the
// marks, passes over every vertex and scans the neighbor slots of each undecided vertex,
// one memory access at a time. The report follows the last round.
// Configuration registers vertex_count and adjacency_count are written through wr_en,
// wr_index and wr_data; the user must write them only while the block is idle (not enforced).
// After reset a clearing pass sets every mark of the current mark RAM to not in set;
// busy stays high during it and no request is taken. Configuration writes still work.
// Results cannot be stalled: done is high for exactly one cycle per result.
module maximal_independent_set_csr #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_SLOTS    = 8192,
	parameter int ROUND_LIMIT  = 100,
	parameter int KEY_BITS     = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       operation,
	input  logic [mis_pkg::INDEX_BITS-1:0]   index,
	input  logic [mis_pkg::SLOT_BITS-1:0]    first_slot,
	input  logic                             candidate,
	input  logic [mis_pkg::REQ_KEY_BITS-1:0] priority_req,
	input  logic [mis_pkg::NBR_BITS-1:0]     neighbor,
	input  logic                             wr_en,
	input  logic                             wr_index,
	input  logic [mis_pkg::SLOT_BITS-1:0]    wr_data,
	output logic                             done,
	output logic                             kind,
	output logic                             in_set,
	output logic [mis_pkg::ROUNDS_BITS-1:0]  rounds_used,
	output logic                             failed
);
	localparam int VA = $clog2(MAX_VERTICES);
	localparam int VW = $clog2(MAX_VERTICES + 1);
	localparam int SA = $clog2(MAX_SLOTS);
	localparam int SW = $clog2(MAX_SLOTS + 1);
	localparam int RW = $clog2(ROUND_LIMIT + 1);
	localparam int MB = mis_pkg::MARK_BITS;
	localparam int FS = mis_pkg::SLOT_BITS;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_READ   = 4'd2;
	localparam logic [3:0] ST_INIT_A = 4'd3;
	localparam logic [3:0] ST_INIT_B = 4'd4;
	localparam logic [3:0] ST_COPY_A = 4'd5;
	localparam logic [3:0] ST_COPY_B = 4'd6;
	localparam logic [3:0] ST_VA     = 4'd7;
	localparam logic [3:0] ST_VB     = 4'd8;
	localparam logic [3:0] ST_VC     = 4'd9;
	localparam logic [3:0] ST_NS     = 4'd10;
	localparam logic [3:0] ST_NM     = 4'd11;
	localparam logic [3:0] ST_NP     = 4'd12;

	logic [3:0]                     state_q;
	logic [VW-1:0]                  v_q;
	logic [SW-1:0]                  s_q;
	logic [SW-1:0]                  hi_q;
	logic [mis_pkg::NBR_BITS-1:0]   u_q;
	logic [MB-1:0]                  mark_v_q;
	logic [KEY_BITS-1:0]            mine_q;
	logic                           lose_q;
	logic                           open_q;
	logic [RW-1:0]                  r_q;
	logic [mis_pkg::VCOUNT_BITS-1:0] vcount_q;
	logic [FS-1:0]                  adj_q;
	logic                           done_q;
	logic                           kind_q;
	logic                           in_set_q;
	logic [mis_pkg::ROUNDS_BITS-1:0] rounds_q;
	logic                           failed_q;

	logic [VW-1:0]   n;
	logic            accept;
	logic [RW-1:0]   r_next;

	logic            vm_we;
	logic [VA-1:0]   vm_waddr, vm_raddr;
	logic [FS:0]     vm_wdata, vm_rdata;
	logic            pr_we;
	logic [VA-1:0]   pr_raddr;
	logic [KEY_BITS-1:0] pr_rdata;
	logic            nb_we;
	logic [SA-1:0]   nb_raddr;
	logic [mis_pkg::NBR_BITS-1:0] nb_rdata;
	logic            mc_we;
	logic [VA-1:0]   mc_waddr, mc_raddr;
	logic [MB-1:0]   mc_wdata, mc_rdata;
	logic            mp_we;
	logic [VA-1:0]   mp_raddr;
	logic [MB-1:0]   mp_rdata;

	logic [SW-1:0]   lo_clamped;
	logic [SW-1:0]   hi_clamped;
	logic            u_valid;
	logic            u_beats;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign r_next = r_q + RW'(1);
	assign n = (32'(vcount_q) > 32'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : VW'(vcount_q);

	assign lo_clamped = (32'(vm_rdata[FS-1:0]) > 32'(MAX_SLOTS)) ?
		SW'(MAX_SLOTS) : SW'(vm_rdata[FS-1:0]);
	always_comb begin
		logic [FS-1:0] h;
		h = (32'(v_q) + 32'd1 < 32'(n)) ? vm_rdata[FS-1:0] : adj_q;
		hi_clamped = (32'(h) > 32'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(h);
	end

	assign u_valid = 32'(nb_rdata) < 32'(n);
	assign u_beats = (mine_q < pr_rdata) ||
		((mine_q == pr_rdata) && (32'(u_q) < 32'(v_q)));

	always_comb begin
		vm_we    = accept && (operation == mis_pkg::OP_LOAD_VERTEX) &&
			(32'(index) < 32'(MAX_VERTICES));
		vm_waddr = VA'(index);
		vm_wdata = {candidate, first_slot};
		pr_we    = vm_we;
		nb_we    = accept && (operation == mis_pkg::OP_LOAD_SLOT) &&
			(32'(index) < 32'(MAX_SLOTS));
		vm_raddr = VA'(v_q);
		pr_raddr = VA'(v_q);
		nb_raddr = SA'(s_q);
		mp_raddr = VA'(v_q);
		mc_raddr = VA'(v_q);
		mc_we    = 1'b0;
		mc_waddr = VA'(v_q);
		mc_wdata = mis_pkg::MARK_OUT;
		mp_we    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				mc_raddr = VA'(index);
			end
			ST_CLEAR: begin
				mc_we = 1'b1;
			end
			ST_INIT_B: begin
				mc_we    = 1'b1;
				mc_wdata = vm_rdata[FS] ? mis_pkg::MARK_OPEN : mis_pkg::MARK_OUT;
			end
			ST_COPY_B: begin
				mp_we = 1'b1;
			end
			ST_VB: begin
				vm_raddr = VA'(v_q + VW'(1));
			end
			ST_NM: begin
				mp_raddr = VA'(nb_rdata);
				pr_raddr = VA'(nb_rdata);
			end
			ST_NS: begin
				mc_we    = (s_q >= hi_q);
				mc_wdata = lose_q ? mis_pkg::MARK_OPEN : mis_pkg::MARK_IN;
			end
			ST_NP: begin
				mc_we    = (mp_rdata == mis_pkg::MARK_IN);
				mc_wdata = mis_pkg::MARK_OUT;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			v_q      <= '0;
			s_q      <= '0;
			hi_q     <= '0;
			u_q      <= '0;
			mark_v_q <= mis_pkg::MARK_OUT;
			mine_q   <= '0;
			open_q   <= 1'b0;
			lose_q   <= 1'b0;
			r_q      <= '0;
			vcount_q <= '0;
			adj_q    <= '0;
			done_q   <= 1'b0;
			kind_q   <= mis_pkg::KIND_SOLVE;
			in_set_q <= 1'b0;
			rounds_q <= '0;
			failed_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (wr_en) begin
				if (wr_index == mis_pkg::REG_VERTEX_COUNT) begin
					vcount_q <= wr_data[mis_pkg::VCOUNT_BITS-1:0];
				end else begin
					adj_q <= wr_data;
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					v_q <= v_q + VW'(1);
					if (32'(v_q) == 32'(MAX_VERTICES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (operation)
							mis_pkg::OP_SOLVE: begin
								v_q     <= '0;
								r_q     <= '0;
								state_q <= ST_INIT_A;
							end
							mis_pkg::OP_READ: begin
								if (32'(index) < 32'(MAX_VERTICES)) begin
									state_q <= ST_READ;
								end else begin
									done_q   <= 1'b1;
									kind_q   <= mis_pkg::KIND_READ;
									in_set_q <= 1'b0;
									rounds_q <= '0;
									failed_q <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					done_q   <= 1'b1;
					kind_q   <= mis_pkg::KIND_READ;
					in_set_q <= (mc_rdata == mis_pkg::MARK_IN);
					rounds_q <= '0;
					failed_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				ST_INIT_A: begin
					if (v_q == n) begin
						v_q     <= '0;
						state_q <= ST_COPY_A;
					end else begin
						state_q <= ST_INIT_B;
					end
				end
				ST_INIT_B: begin
					v_q     <= v_q + VW'(1);
					state_q <= ST_INIT_A;
				end
				ST_COPY_A: begin
					if (v_q == n) begin
						v_q     <= '0;
						open_q  <= 1'b0;
						state_q <= ST_VA;
					end else begin
						state_q <= ST_COPY_B;
					end
				end
				ST_COPY_B: begin
					v_q     <= v_q + VW'(1);
					state_q <= ST_COPY_A;
				end
				ST_VA: begin
					if (v_q == n) begin
						r_q <= r_next;
						v_q <= '0;
						if ((32'(r_next) < 32'(ROUND_LIMIT)) && open_q) begin
							state_q <= ST_COPY_A;
						end else begin
							done_q   <= 1'b1;
							kind_q   <= mis_pkg::KIND_SOLVE;
							in_set_q <= 1'b0;
							rounds_q <= mis_pkg::ROUNDS_BITS'(r_next);
							failed_q <= open_q;
							state_q  <= ST_IDLE;
						end
					end else begin
						state_q <= ST_VB;
					end
				end
				ST_VB: begin
					mark_v_q <= mp_rdata;
					s_q      <= lo_clamped;
					mine_q   <= pr_rdata;
					lose_q   <= 1'b0;
					state_q  <= ST_VC;
				end
				ST_VC: begin
					hi_q <= hi_clamped;
					if (mark_v_q != mis_pkg::MARK_OPEN) begin
						v_q     <= v_q + VW'(1);
						state_q <= ST_VA;
					end else begin
						state_q <= ST_NS;
					end
				end
				ST_NS: begin
					if (s_q >= hi_q) begin
						if (lose_q) begin
							open_q <= 1'b1;
						end
						v_q     <= v_q + VW'(1);
						state_q <= ST_VA;
					end else begin
						state_q <= ST_NM;
					end
				end
				ST_NM: begin
					u_q <= nb_rdata;
					if (u_valid) begin
						state_q <= ST_NP;
					end else begin
						s_q     <= s_q + SW'(1);
						state_q <= ST_NS;
					end
				end
				ST_NP: begin
					if (mp_rdata == mis_pkg::MARK_IN) begin
						v_q     <= v_q + VW'(1);
						state_q <= ST_VA;
					end else begin
						if ((mp_rdata != mis_pkg::MARK_OUT) && u_beats) begin
							lose_q <= 1'b1;
						end
						s_q     <= s_q + SW'(1);
						state_q <= ST_NS;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	mis_ram #(.WIDTH(FS + 1), .DEPTH(MAX_VERTICES)) u_vertex_ram (
		.clk(clk), .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
		.raddr(vm_raddr), .rdata(vm_rdata)
	);

	mis_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_VERTICES)) u_key_ram (
		.clk(clk), .we(pr_we), .waddr(vm_waddr), .wdata(KEY_BITS'(priority_req)),
		.raddr(pr_raddr), .rdata(pr_rdata)
	);

	mis_ram #(.WIDTH(mis_pkg::NBR_BITS), .DEPTH(MAX_SLOTS)) u_slot_ram (
		.clk(clk), .we(nb_we), .waddr(SA'(index)), .wdata(neighbor),
		.raddr(nb_raddr), .rdata(nb_rdata)
	);

	mis_ram #(.WIDTH(MB), .DEPTH(MAX_VERTICES)) u_mark_cur_ram (
		.clk(clk), .we(mc_we), .waddr(mc_waddr), .wdata(mc_wdata),
		.raddr(mc_raddr), .rdata(mc_rdata)
	);

	mis_ram #(.WIDTH(MB), .DEPTH(MAX_VERTICES)) u_mark_prev_ram (
		.clk(clk), .we(mp_we), .waddr(VA'(v_q)), .wdata(mc_rdata),
		.raddr(mp_raddr), .rdata(mp_rdata)
	);

	assign done        = done_q;
	assign kind        = kind_q;
	assign in_set      = in_set_q;
	assign rounds_used = rounds_q;
	assign failed      = failed_q;
endmodule
